/* design/c8x_pkg.sv */
// Shared types, constants and helpers for the chip8 execute unit.
// No dependencies.
package c8x_pkg;

    localparam int SCREEN_WIDTH_DEF  = 64;
    localparam int SCREEN_HEIGHT_DEF = 32;
    localparam int MEM_BYTES_DEF     = 4096;
    localparam int STACK_DEPTH_DEF   = 16;
    localparam logic [11:0] PROG_START_RST = 12'h200;

    localparam logic [1:0] KIND_EXEC  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;
    localparam logic [1:0] KIND_PIXEL = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] instruction;
        logic [11:0] address;
        logic [7:0]  write_byte;
        logic [15:0] key_mask;
        logic [7:0]  random_byte;
    } c8x_in_t;

    typedef struct packed {
        logic [11:0] next_pc;
        logic [7:0]  read_value;
        logic        waiting_key;
        logic        stack_fault;
    } c8x_out_t;

    // Linear key position of a key value.
    function automatic logic [3:0] key_lin(input logic [3:0] v);
        logic [3:0] r;
        case (v)
            4'h0: r = 4'd13; 4'h1: r = 4'd0;  4'h2: r = 4'd1;  4'h3: r = 4'd2;
            4'h4: r = 4'd4;  4'h5: r = 4'd5;  4'h6: r = 4'd6;  4'h7: r = 4'd8;
            4'h8: r = 4'd9;  4'h9: r = 4'd10; 4'hA: r = 4'd12; 4'hB: r = 4'd14;
            4'hC: r = 4'd3;  4'hD: r = 4'd7;  4'hE: r = 4'd11; default: r = 4'd15;
        endcase
        return r;
    endfunction

    // Key value of a linear key position.
    function automatic logic [3:0] key_val(input logic [3:0] k);
        logic [3:0] r;
        case (k)
            4'd0: r = 4'h1;  4'd1: r = 4'h2;  4'd2: r = 4'h3;  4'd3: r = 4'hC;
            4'd4: r = 4'h4;  4'd5: r = 4'h5;  4'd6: r = 4'h6;  4'd7: r = 4'hD;
            4'd8: r = 4'h7;  4'd9: r = 4'h8;  4'd10: r = 4'h9; 4'd11: r = 4'hE;
            4'd12: r = 4'hA; 4'd13: r = 4'h0; 4'd14: r = 4'hB; default: r = 4'hF;
        endcase
        return r;
    endfunction

endpackage

/* design/chip8_instruction_execute.sv */
// CHIP-8 execute unit top level: sequencer, registers, memory and screen.
// Depends on c8x_pkg, c8x_mem, c8x_fb.

// One beat in, one beat out per item, one item at a time. Register,
// arithmetic, jump, skip, key and memory items pass through the execute
// and finish states; BCD writes its three digits in turn; block save writes
// one register per cycle and block load reads one per cycle; a draw reads
// one memory byte per row, tests each sprite bit and does a read-modify-write
// of the frame buffer for each set sprite bit, which is what sets the length
// of the draw; clear screen sweeps every pixel, one per cycle. After reset the
// screen is cleared by a sweep over every pixel during which no input beat is
// taken. The result sits in an output register, so the next beat is taken
// only when the output is free again.
module chip8_instruction_execute
    import c8x_pkg::*;
#(
    parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
    parameter int MEM_BYTES     = MEM_BYTES_DEF,
    parameter int STACK_DEPTH   = STACK_DEPTH_DEF
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  c8x_in_t     in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output c8x_out_t    out_data,
    input  logic        cfg_we,
    input  logic [11:0] cfg_data
);
    localparam int PIXELS = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int PW = $clog2(PIXELS);
    localparam int AW = $clog2(MEM_BYTES);
    localparam int SW = $clog2(STACK_DEPTH);
    localparam int XW = $clog2(SCREEN_WIDTH);

    typedef enum logic [10:0] {
        ST_CLEAR = 11'b00000000001,
        ST_IDLE  = 11'b00000000010,
        ST_EXEC  = 11'b00000000100,
        ST_RDWT  = 11'b00000001000,
        ST_BCD   = 11'b00000010000,
        ST_SAVE  = 11'b00000100000,
        ST_LOAD  = 11'b00001000000,
        ST_DROW  = 11'b00010000000,
        ST_DPIX  = 11'b00100000000,
        ST_DRMW  = 11'b01000000000,
        ST_DONE  = 11'b10000000000
    } st_t;

    st_t st_reg, st_next;
    c8x_in_t item_reg;
    logic [7:0]  v_reg [16];
    logic [15:0] i_reg;
    logic [11:0] pc_reg, pcs_reg;
    logic [SW-1:0] sp_reg;
    logic [11:0] stk_reg [STACK_DEPTH];
    logic [7:0]  dt_reg, st8_reg;
    logic [PW-1:0] cnt_reg;
    logic [4:0]  k_reg;
    logic [3:0]  row_reg;
    logic [2:0]  col_reg;
    logic [7:0]  line_reg, dx_reg, dy_reg;
    logic        hit_reg;
    logic        ov_reg;
    c8x_out_t    out_reg;
    logic        mem_we, fb_we, fb_wd, fb_rd;
    logic [AW-1:0] mem_a;
    logic [7:0]  mem_wd, mem_rd;
    logic [PW-1:0] fb_a;

    c8x_mem #(.MEM_BYTES(MEM_BYTES)) u_mem (
        .clk(clk), .we(mem_we), .addr(mem_a), .wdata(mem_wd), .rdata(mem_rd));
    c8x_fb #(.PIXELS(PIXELS)) u_fb (
        .clk(clk), .we(fb_we), .addr(fb_a), .wdata(fb_wd), .rdata(fb_rd));

    // Decode fields of the held item.
    logic [3:0] op, x, y, n;
    logic [7:0] nn, vx, vy;
    logic [11:0] nnn, pc2, pc4;
    always_comb
    begin
        op  = item_reg.instruction[15:12];
        x   = item_reg.instruction[11:8];
        y   = item_reg.instruction[7:4];
        n   = item_reg.instruction[3:0];
        nn  = item_reg.instruction[7:0];
        nnn = item_reg.instruction[11:0];
        vx  = v_reg[x];
        vy  = v_reg[y];
        pc2 = pc_reg + 12'd2;
        pc4 = pc_reg + 12'd4;
    end

    // Pixel index of the current sprite bit, wrapped to the screen size.
    logic [15:0] px_lin;
    logic [PW-1:0] px_idx;
    always_comb
    begin
        px_lin = 16'(dx_reg) + 16'(col_reg)
               + ((16'(dy_reg) + 16'(row_reg)) << XW);
        px_idx = PW'(px_lin);
    end

    // BCD digits via small shared arithmetic.
    logic [7:0] hund, tens, ones;
    always_comb
    begin
        hund = (vx >= 8'd200) ? 8'd2 : (vx >= 8'd100) ? 8'd1 : 8'd0;
        ones = vx - 8'(hund * 8'd100);
        tens = 8'((16'(ones) * 16'd205) >> 11);
        ones = ones - 8'(tens * 8'd10);
    end

    // First down key, scanned from linear key 0.
    logic        any_key;
    logic [3:0]  first_key;
    always_comb
    begin
        any_key = 1'b0;
        first_key = 4'd0;
        for (int k = 15; k >= 0; k--)
        begin
            if (item_reg.key_mask[k])
            begin
                any_key = 1'b1;
                first_key = 4'(k);
            end
        end
    end

    logic key_dn;
    assign key_dn = (vx[7:4] == 4'd0) && item_reg.key_mask[key_lin(vx[3:0])];

    // Take an input beat only when idle and the output register is free.
    assign in_stall  = !(st_reg == ST_IDLE) || out_valid;
    assign out_data  = out_reg;

    logic in_acc;
    assign in_acc = in_valid && !in_stall;

    // Memory and frame buffer port control.
    always_comb
    begin
        mem_we = 1'b0;
        mem_a  = AW'(item_reg.address);
        mem_wd = item_reg.write_byte;
        fb_we  = 1'b0;
        fb_a   = PW'(item_reg.address);
        fb_wd  = 1'b0;
        case (st_reg)
            ST_CLEAR:
            begin
                fb_we = 1'b1;
                fb_a  = cnt_reg;
            end
            ST_EXEC:
            begin
                if (item_reg.kind == KIND_WRITE)
                begin
                    mem_we = 1'b1;
                end
                else if (item_reg.kind == KIND_EXEC && op == 4'hF && nn == 8'h33)
                begin
                    mem_we = 1'b1;
                    mem_a  = AW'(i_reg);
                    mem_wd = hund;
                end
            end
            ST_BCD:
            begin
                mem_we = 1'b1;
                mem_a  = AW'(i_reg + 16'(k_reg));
                mem_wd = (k_reg == 5'd1) ? tens : ones;
            end
            ST_SAVE:
            begin
                mem_we = 1'b1;
                mem_a  = AW'(i_reg + 16'(k_reg));
                mem_wd = v_reg[k_reg[3:0]];
            end
            ST_LOAD:
            begin
                mem_a = AW'(i_reg + 16'(k_reg));
            end
            ST_DROW:
            begin
                mem_a = AW'(i_reg + 16'(row_reg));
            end
            ST_DPIX:
            begin
                fb_a = px_idx;
            end
            ST_DRMW:
            begin
                fb_a  = px_idx;
                fb_we = 1'b1;
                fb_wd = !fb_rd;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= ST_CLEAR;
            cnt_reg   <= '0;
            pc_reg    <= PROG_START_RST;
            pcs_reg   <= PROG_START_RST;
            i_reg     <= '0;
            sp_reg    <= '0;
            dt_reg    <= '0;
            st8_reg   <= '0;
            out_valid <= 1'b0;
            for (int r = 0; r < 16; r++)
            begin
                v_reg[r] <= '0;
            end
        end
        else
        begin
            st_reg <= st_next;
            if (out_valid && !out_stall)
            begin
                out_valid <= 1'b0;
            end
            if (cfg_we)
            begin
                pcs_reg <= cfg_data;
                pc_reg  <= cfg_data;
            end
            case (st_reg)
                ST_CLEAR:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
                ST_EXEC:
                begin
                    cnt_reg <= '0;
                    if (item_reg.kind == KIND_EXEC)
                    begin
                        out_reg.next_pc <= pc2;
                        pc_reg <= pc2;
                        case (op)
                            4'h0:
                            begin
                                if (item_reg.instruction == 16'h00EE && sp_reg != '0)
                                begin
                                    out_reg.next_pc <= stk_reg[sp_reg];
                                    pc_reg <= stk_reg[sp_reg];
                                    sp_reg <= sp_reg - 1'b1;
                                end
                            end
                            4'h1:
                            begin
                                out_reg.next_pc <= nnn;
                                pc_reg <= nnn;
                            end
                            4'h2:
                            begin
                                if (sp_reg != SW'(STACK_DEPTH - 1))
                                begin
                                    stk_reg[sp_reg + 1'b1] <= pc2;
                                    sp_reg <= sp_reg + 1'b1;
                                end
                                else
                                begin
                                    stk_reg[sp_reg] <= pc2;
                                    out_reg.stack_fault <= 1'b1;
                                end
                                out_reg.next_pc <= nnn;
                                pc_reg <= nnn;
                            end
                            4'h3, 4'h4, 4'h5, 4'h9, 4'hE:
                            begin
                                if ((op == 4'h3 && vx == nn) || (op == 4'h4 && vx != nn)
                                    || (op == 4'h5 && n == 4'd0 && vx == vy)
                                    || (op == 4'h9 && n == 4'd0 && vx != vy)
                                    || (op == 4'hE && nn == 8'h9E && key_dn)
                                    || (op == 4'hE && nn == 8'hA1 && !key_dn))
                                begin
                                    out_reg.next_pc <= pc4;
                                    pc_reg <= pc4;
                                end
                            end
                            4'h6: v_reg[x] <= nn;
                            4'h7: v_reg[x] <= vx + nn;
                            4'h8:
                            begin
                                case (n)
                                    4'h0: v_reg[x] <= vy;
                                    4'h1: v_reg[x] <= vx | vy;
                                    4'h2: v_reg[x] <= vx & vy;
                                    4'h3: v_reg[x] <= vx ^ vy;
                                    4'h4:
                                    begin
                                        v_reg[15] <= 8'(({1'b0, vx} + {1'b0, vy}) >> 8);
                                        v_reg[x] <= vx + vy;
                                    end
                                    4'h5:
                                    begin
                                        v_reg[15] <= 8'(vx >= vy);
                                        v_reg[x] <= vx - vy;
                                    end
                                    4'h6:
                                    begin
                                        v_reg[15] <= 8'(vx[0]);
                                        v_reg[x] <= vx >> 1;
                                    end
                                    4'h7:
                                    begin
                                        v_reg[15] <= 8'(vy >= vx);
                                        v_reg[x] <= vy - vx;
                                    end
                                    4'hE:
                                    begin
                                        v_reg[15] <= 8'(vx[7]);
                                        v_reg[x] <= vx << 1;
                                    end
                                    default:
                                    begin
                                    end
                                endcase
                            end
                            4'hA: i_reg <= 16'(nnn);
                            4'hB:
                            begin
                                out_reg.next_pc <= nnn + 12'(v_reg[0]);
                                pc_reg <= nnn + 12'(v_reg[0]);
                            end
                            4'hC: v_reg[x] <= item_reg.random_byte & nn;
                            4'hD:
                            begin
                                dx_reg  <= vx;
                                dy_reg  <= vy;
                                row_reg <= '0;
                                hit_reg <= 1'b0;
                            end
                            default:
                            begin
                                case (nn)
                                    8'h07: v_reg[x] <= dt_reg;
                                    8'h0A:
                                    begin
                                        if (any_key)
                                        begin
                                            v_reg[x] <= key_val(first_key);
                                        end
                                        else
                                        begin
                                            out_reg.next_pc <= pc_reg;
                                            pc_reg <= pc_reg;
                                            out_reg.waiting_key <= 1'b1;
                                        end
                                    end
                                    8'h15: dt_reg <= vx;
                                    8'h18: st8_reg <= vx;
                                    8'h1E: i_reg <= i_reg + 16'(vx);
                                    8'h29: i_reg <= 16'(vx) * 16'd5;
                                    default:
                                    begin
                                    end
                                endcase
                                k_reg <= (nn == 8'h33) ? 5'd1 : 5'd0;
                            end
                        endcase
                    end
                end
                ST_BCD:
                begin
                    k_reg <= k_reg + 1'b1;
                end
                ST_SAVE:
                begin
                    k_reg <= k_reg + 1'b1;
                end
                ST_LOAD:
                begin
                    k_reg <= k_reg + 1'b1;
                    if (k_reg != 5'd0)
                    begin
                        v_reg[4'(k_reg - 1'b1)] <= mem_rd;
                    end
                end
                ST_RDWT:
                begin
                    line_reg <= mem_rd;
                    col_reg  <= '0;
                end
                ST_DPIX:
                begin
                    if (!line_reg[3'd7 - col_reg])
                    begin
                        col_reg <= col_reg + 1'b1;
                        if (col_reg == 3'd7)
                        begin
                            row_reg <= row_reg + 1'b1;
                        end
                    end
                end
                ST_DRMW:
                begin
                    hit_reg <= hit_reg | fb_rd;
                    col_reg <= col_reg + 1'b1;
                    if (col_reg == 3'd7)
                    begin
                        row_reg <= row_reg + 1'b1;
                    end
                end
                ST_DONE:
                begin
                    if (item_reg.kind == KIND_EXEC && op == 4'hD)
                    begin
                        v_reg[15] <= 8'(hit_reg);
                    end
                    if (item_reg.kind == KIND_READ)
                    begin
                        out_reg.read_value <= mem_rd;
                    end
                    else if (item_reg.kind == KIND_PIXEL)
                    begin
                        out_reg.read_value <= 8'(fb_rd);
                    end
                    out_valid <= 1'b1;
                end
                default:
                begin
                end
            endcase
            if (in_acc)
            begin
                item_reg <= in_data;
                out_reg.next_pc     <= pc_reg;
                out_reg.read_value  <= '0;
                out_reg.waiting_key <= 1'b0;
                out_reg.stack_fault <= 1'b0;
            end
        end
    end

    // Sequencer.
    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            ST_CLEAR:
            begin
                if (cnt_reg == PW'(PIXELS - 1))
                begin
                    st_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    st_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                st_next = ST_DONE;
                if (item_reg.kind == KIND_EXEC)
                begin
                    if (item_reg.instruction == 16'h00E0)
                    begin
                        st_next = ST_CLEAR;
                    end
                    else if (op == 4'hD)
                    begin
                        st_next = (n == 4'd0) ? ST_DONE : ST_DROW;
                    end
                    else if (op == 4'hF && nn == 8'h33)
                    begin
                        st_next = ST_BCD;
                    end
                    else if (op == 4'hF && nn == 8'h55)
                    begin
                        st_next = ST_SAVE;
                    end
                    else if (op == 4'hF && nn == 8'h65)
                    begin
                        st_next = ST_LOAD;
                    end
                end
            end
            ST_BCD:
            begin
                if (k_reg == 5'd2)
                begin
                    st_next = ST_DONE;
                end
            end
            ST_SAVE:
            begin
                if (k_reg[3:0] == x)
                begin
                    st_next = ST_DONE;
                end
            end
            ST_LOAD:
            begin
                if (k_reg == 5'(x) + 5'd1)
                begin
                    st_next = ST_DONE;
                end
            end
            ST_DROW: st_next = ST_RDWT;
            ST_RDWT: st_next = ST_DPIX;
            ST_DPIX:
            begin
                if (line_reg[3'd7 - col_reg])
                begin
                    st_next = ST_DRMW;
                end
                else if (col_reg == 3'd7)
                begin
                    st_next = (row_reg + 1'b1 == n) ? ST_DONE : ST_DROW;
                end
            end
            ST_DRMW:
            begin
                if (col_reg == 3'd7)
                begin
                    st_next = (row_reg + 1'b1 == n) ? ST_DONE : ST_DROW;
                end
                else
                begin
                    st_next = ST_DPIX;
                end
            end
            ST_DONE: st_next = ST_IDLE;
            default: st_next = ST_IDLE;
        endcase
        // Clear screen by opcode returns the result after the sweep.
        if (st_reg == ST_CLEAR && cnt_reg == PW'(PIXELS - 1) && ov_reg)
        begin
            st_next = ST_DONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (st_reg == ST_EXEC)
        begin
            ov_reg <= 1'b1;
        end
    end

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |-> (st_reg == ST_IDLE))
        else $error("beat taken while busy");
    a_sp_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(sp_reg) < STACK_DEPTH)
        else $error("stack pointer out of range");
    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(st_reg == ST_DONE))
        else $error("result without finish");
`endif
endmodule

/* design/c8x_mem.sv */
// Byte memory: one synchronous port, registered read data.
// Depends on c8x_pkg.
module c8x_mem
    import c8x_pkg::*;
#(
    parameter int MEM_BYTES = MEM_BYTES_DEF,
    localparam int AW = $clog2(MEM_BYTES)
)(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] addr,
    input  logic [7:0]    wdata,
    output logic [7:0]    rdata
);
    logic [7:0] mem [MEM_BYTES];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

/* design/c8x_fb.sv */
// Frame buffer, one bit per pixel, one synchronous port.
// Depends on c8x_pkg.
module c8x_fb
    import c8x_pkg::*;
#(
    parameter int PIXELS = SCREEN_WIDTH_DEF * SCREEN_HEIGHT_DEF,
    localparam int PW = $clog2(PIXELS)
)(
    input  logic          clk,
    input  logic          we,
    input  logic [PW-1:0] addr,
    input  logic          wdata,
    output logic          rdata
);
    logic mem [PIXELS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
